/* sv/assert_macros.svh */
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: label");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: label");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* sv/fbpool_pkg.sv */
package fbpool_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;

	localparam int SIZE_W     = 16;
	localparam int ALIGN_W    = 8;
	localparam int COUNT_W    = 11;
	localparam int BLOCK_W    = 10;
	localparam int USED_W     = 26;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd64;
	localparam logic [ALIGN_W-1:0] ALIGN_RESET = 8'd8;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

	typedef enum logic [S_TUSER_W-1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_RESET  = 2'd2,
		REQ_UNUSED = 2'd3
	} req_type_t;

	typedef enum logic [M_TUSER_W-1:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_BAD_SIZE  = 3'd2,
		ST_BAD_ALIGN = 3'd3,
		ST_POOL_FULL = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE  = 2'd0,
		REG_BLOCK_ALIGN = 2'd1,
		REG_BLOCK_COUNT = 2'd2
	} reg_index_t;

endpackage

/* sv/fixed_block_pool_free_list_core.sv */
// Fixed-size block pool allocator that keeps its free blocks as a linked list of block indices
// in a single-port-write, synchronous-read next-link memory of NUM_BLOCKS entries, with the
// list head and the used-byte total in registers. Allocate and free requests pass through the
// transfer cycle, in which an allocate issues the read of the head's link, and the execute
// state, where the result is formed and the state updated when the output register is free.
// A pool reset request rebuilds the chain by writing one link per cycle. After arst_n the same
// chain-building pass runs with the reset configuration, and no request is accepted until it
// ends; configuration writes are taken at any time. Requests travel with req_type in tuser,
// results with status in tuser. A new request is accepted while a previous result still waits
// in the output register.
`include "assert_macros.svh"

module fixed_block_pool_free_list_core
	import fbpool_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// req_size [15:0], req_alignment [23:16], free_block [33:24], zero fill [39:34]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// req_type [1:0]
	input  logic [S_TUSER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// granted_block [9:0], used_bytes [35:10], zero fill [39:36]
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status [2:0]
	output logic [M_TUSER_W-1:0]  m_tuser
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int LW = $clog2(NUM_BLOCKS + 1);
	localparam logic [LW-1:0] LINK_NULL = LW'(NUM_BLOCKS);
	localparam int INIT_N = (int'(COUNT_RESET) > NUM_BLOCKS) ? NUM_BLOCKS : int'(COUNT_RESET);
	localparam logic [AW-1:0] INIT_LAST = AW'(INIT_N - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]  block_size_q;
	logic [ALIGN_W-1:0] block_align_q;
	logic [COUNT_W-1:0] block_count_q;

	logic [LW-1:0]     head_q;
	logic [USED_W-1:0] used_q;
	logic [AW-1:0]     sweep_idx_q;
	logic [AW-1:0]     sweep_last_q;
	logic              init_q;

	req_type_t          req_type_s1;
	logic [SIZE_W-1:0]  req_size_s1;
	logic [ALIGN_W-1:0] req_align_s1;
	logic [BLOCK_W-1:0] free_block_s1;

	logic [LW-1:0] link_mem [NUM_BLOCKS];
	logic [LW-1:0] rd_data_s1;

	logic                m_tvalid_q;
	status_t             status_q;
	logic [BLOCK_W-1:0]  granted_q;
	logic [USED_W-1:0]   used_out_q;

	logic          accept;
	logic          slot_free;
	logic          free_ok;
	logic          mem_re;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;
	logic [31:0]   chain_n;
	logic [USED_W:0]   used_sum;
	logic [USED_W-1:0] used_add;
	logic [USED_W-1:0] used_sub;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign free_ok   = 32'(free_block_s1) < 32'(NUM_BLOCKS);

	assign chain_n = (32'(block_count_q) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS)
		: 32'(block_count_q);

	assign used_sum = {1'b0, used_q} + (USED_W + 1)'(block_size_q);
	assign used_add = used_sum[USED_W] ? USED_MAX : used_sum[USED_W-1:0];
	assign used_sub = (used_q < USED_W'(block_size_q)) ? '0
		: used_q - USED_W'(block_size_q);

	assign mem_re = accept && (s_tuser == REQ_ALLOC);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_idx_q;
		mem_wdata = (sweep_idx_q == sweep_last_q) ? LINK_NULL
			: LW'(sweep_idx_q) + LW'(1);
		if (state_q == S_SWEEP) begin
			mem_we = 1'b1;
		end else if (state_q == S_EXEC && slot_free && req_type_s1 == REQ_FREE && free_ok) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(free_block_s1);
			mem_wdata = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= link_mem[head_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= SIZE_RESET;
			block_align_q <= ALIGN_RESET;
			block_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SIZE:  block_size_q  <= cfg_data[SIZE_W-1:0];
				REG_BLOCK_ALIGN: block_align_q <= cfg_data[ALIGN_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1   <= req_type_t'(s_tuser);
			req_size_s1   <= s_tdata[15:0];
			req_align_s1  <= s_tdata[23:16];
			free_block_s1 <= s_tdata[33:24];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && slot_free && req_type_s1 != REQ_RESET) begin
			status_q   <= ST_OK;
			granted_q  <= '0;
			used_out_q <= used_q;
			case (req_type_s1)
				REQ_ALLOC: begin
					if (req_size_s1 == '0) begin
						status_q <= ST_ZERO_SIZE;
					end else if (req_size_s1 != block_size_q) begin
						status_q <= ST_BAD_SIZE;
					end else if (req_align_s1 != block_align_q) begin
						status_q <= ST_BAD_ALIGN;
					end else if (head_q == LINK_NULL) begin
						status_q <= ST_POOL_FULL;
					end else begin
						granted_q  <= BLOCK_W'(32'(head_q));
						used_out_q <= used_add;
					end
				end
				REQ_FREE: begin
					if (free_ok) begin
						used_out_q <= used_sub;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_FIN && slot_free) begin
			status_q   <= ST_OK;
			granted_q  <= '0;
			used_out_q <= used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			init_q       <= 1'b1;
			head_q       <= '0;
			used_q       <= '0;
			sweep_idx_q  <= '0;
			sweep_last_q <= INIT_LAST;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (req_type_s1 == REQ_RESET) begin
						used_q <= '0;
						if (chain_n == 32'd0) begin
							head_q  <= LINK_NULL;
							state_q <= S_FIN;
						end else begin
							head_q       <= '0;
							sweep_idx_q  <= '0;
							sweep_last_q <= AW'(chain_n - 32'd1);
							state_q      <= S_SWEEP;
						end
					end else if (slot_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
						if (req_type_s1 == REQ_ALLOC && req_size_s1 != '0
							&& req_size_s1 == block_size_q && req_align_s1 == block_align_q
							&& head_q != LINK_NULL) begin
							head_q <= rd_data_s1;
							used_q <= used_add;
						end else if (req_type_s1 == REQ_FREE && free_ok) begin
							head_q <= LW'(free_block_s1);
							used_q <= used_sub;
						end
					end
				end
				S_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + AW'(1);
					if (sweep_idx_q == sweep_last_q) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(M_TDATA_W - BLOCK_W - USED_W){1'b0}}, used_out_q, granted_q};

	`ASSERT_NEVER(a_mem_rw_overlap, clk, arst_n, mem_re && mem_we)
	`ASSERT_PROP(a_head_range, clk, arst_n, head_q <= LINK_NULL)
	`ASSERT_PROP(a_result_source, clk, arst_n,
		$rose(m_tvalid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_FIN))
	`ASSERT_PROP(a_init_no_result, clk, arst_n, init_q |-> !m_tvalid_q)

endmodule

/* tb/fixed_block_pool_free_list_core_test.sv */
module fixed_block_pool_free_list_core_test
	import fbpool_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned LONG_HOLD = 300;
	localparam logic [COUNT_W-1:0] LINK_NULL = COUNT_W'(NUM_BLOCKS_DEF);

	typedef struct packed {
		req_type_t kind;
		logic [SIZE_W-1:0] sz;
		logic [ALIGN_W-1:0] al;
		logic [BLOCK_W-1:0] blk;
	} pool_req_t;

	typedef struct packed {
		status_t status;
		logic [BLOCK_W-1:0] granted;
		logic [USED_W-1:0] used;
	} pool_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	logic [SIZE_W-1:0] cfg_size;
	logic [ALIGN_W-1:0] cfg_align;
	logic [COUNT_W-1:0] cfg_count;
	logic [COUNT_W-1:0] link_of [NUM_BLOCKS_DEF];
	logic [COUNT_W-1:0] free_head;
	logic [USED_W-1:0] used_total;
	logic [BLOCK_W-1:0] held_q [$];

	pool_req_t pending_reqs [$];
	pool_res_t owed_results [$];
	pool_req_t offered;
	pool_res_t want;

	int unsigned queued = 0;
	int unsigned taken = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned tx_gap_max = 15;
	int unsigned rx_gap_max = 15;
	int unsigned tx_gap_left = 0;
	int unsigned rx_wait = 0;
	int unsigned long_asked = 0;
	int unsigned long_done = 0;

	fixed_block_pool_free_list_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void rebuild_chain();
		int unsigned n;
		n = (cfg_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : cfg_count;
		for (int i = 0; i < NUM_BLOCKS_DEF; i++)
			link_of[i] = LINK_NULL;
		for (int i = 0; i + 1 < n; i++)
			link_of[i] = COUNT_W'(i + 1);
		free_head = (n == 0) ? LINK_NULL : '0;
		used_total = '0;
		held_q.delete();
	endfunction

	function automatic void serve_request(pool_req_t r);
		pool_res_t res;
		res.status = ST_OK;
		res.granted = '0;
		case (r.kind)
			REQ_ALLOC: begin
				if (r.sz == 0)
					res.status = ST_ZERO_SIZE;
				else if (r.sz != cfg_size)
					res.status = ST_BAD_SIZE;
				else if (r.al != cfg_align)
					res.status = ST_BAD_ALIGN;
				else if (free_head >= NUM_BLOCKS_DEF)
					res.status = ST_POOL_FULL;
				else begin
					res.granted = free_head[BLOCK_W-1:0];
					held_q.push_back(res.granted);
					free_head = link_of[free_head[BLOCK_W-1:0]];
					if (used_total > USED_MAX - cfg_size)
						used_total = USED_MAX;
					else
						used_total = used_total + cfg_size;
				end
			end
			REQ_FREE: begin
				if (r.blk < NUM_BLOCKS_DEF) begin
					link_of[r.blk] = free_head;
					free_head = COUNT_W'(r.blk);
					if (used_total < cfg_size)
						used_total = '0;
					else
						used_total = used_total - cfg_size;
				end
			end
			REQ_RESET: begin
				rebuild_chain();
			end
			default: begin
			end
		endcase
		res.used = used_total;
		owed_results.push_back(res);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				serve_request(offered);
				taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					offered = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_TDATA_W-SIZE_W-ALIGN_W-BLOCK_W){1'b0}},
						offered.blk, offered.al, offered.sz};
					s_tuser <= offered.kind;
					tx_gap_left = $urandom_range(0, tx_gap_max);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d granted %0d used %0d", $time,
						m_tuser, m_tdata[BLOCK_W-1:0], m_tdata[BLOCK_W+USED_W-1:BLOCK_W]);
					errors++;
				end else begin
					want = owed_results.pop_front();
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, m_tuser);
						errors++;
					end
					if (m_tdata[BLOCK_W-1:0] !== want.granted) begin
						$display("%0t: granted_block expected %0d actual %0d", $time,
							want.granted, m_tdata[BLOCK_W-1:0]);
						errors++;
					end
					if (m_tdata[BLOCK_W+USED_W-1:BLOCK_W] !== want.used) begin
						$display("%0t: used_bytes expected %0d actual %0d", $time,
							want.used, m_tdata[BLOCK_W+USED_W-1:BLOCK_W]);
						errors++;
					end
				end
				rx_wait = $urandom_range(0, rx_gap_max);
			end
			if (long_done != long_asked) begin
				long_done = long_asked;
				rx_wait = LONG_HOLD;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_item(req_type_t kind, logic [SIZE_W-1:0] sz, logic [ALIGN_W-1:0] al,
			logic [BLOCK_W-1:0] blk);
		pool_req_t r;
		while (pending_reqs.size() >= 2)
			@(negedge clk);
		r.kind = kind;
		r.sz = sz;
		r.al = al;
		r.blk = blk;
		pending_reqs.push_back(r);
		queued++;
	endtask

	task automatic wait_drained();
		while (taken != queued || owed_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BLOCK_SIZE: cfg_size = val[SIZE_W-1:0];
			REG_BLOCK_ALIGN: cfg_align = val[ALIGN_W-1:0];
			REG_BLOCK_COUNT: cfg_count = val[COUNT_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed traffic: allocations with the configured size and alignment and frees
	// of blocks that are currently held, with some resets and malformed requests mixed in.
	task automatic push_random_item();
		int unsigned roll;
		int unsigned idx;
		logic [BLOCK_W-1:0] b;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			push_item(REQ_ALLOC, cfg_size, cfg_align, BLOCK_W'($urandom()));
		end else if (roll < 80) begin
			if (held_q.size() > 0) begin
				idx = $urandom_range(0, held_q.size() - 1);
				b = held_q[idx];
				held_q.delete(idx);
			end else begin
				b = BLOCK_W'($urandom());
			end
			push_item(REQ_FREE, SIZE_W'($urandom()), ALIGN_W'($urandom()), b);
		end else if (roll < 83) begin
			push_item(REQ_RESET, SIZE_W'($urandom()), ALIGN_W'($urandom()),
				BLOCK_W'($urandom()));
		end else if (roll < 86) begin
			push_item(REQ_UNUSED, SIZE_W'($urandom()), ALIGN_W'($urandom()),
				BLOCK_W'($urandom()));
		end else if (roll < 95) begin
			case ($urandom_range(0, 3))
				0: push_item(REQ_ALLOC, '0, ALIGN_W'($urandom()), BLOCK_W'($urandom()));
				1: push_item(REQ_ALLOC, SIZE_W'($urandom()), ALIGN_W'($urandom()),
					BLOCK_W'($urandom()));
				2: push_item(REQ_ALLOC, cfg_size, ALIGN_W'($urandom()), BLOCK_W'($urandom()));
				default: push_item(REQ_ALLOC, SIZE_W'($urandom()), cfg_align,
					BLOCK_W'($urandom()));
			endcase
		end else begin
			push_item(REQ_FREE, SIZE_W'($urandom()), ALIGN_W'($urandom()),
				BLOCK_W'($urandom()));
		end
	endtask

	initial begin
		cfg_size = SIZE_RESET;
		cfg_align = ALIGN_RESET;
		cfg_count = COUNT_RESET;
		rebuild_chain();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_item(REQ_ALLOC, 16'd0, 8'd8, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'h3FF);
		push_item(REQ_ALLOC, 16'd64, 8'd0, 10'd0);
		push_item(REQ_ALLOC, 16'd64, 8'hFF, 10'd0);
		push_item(REQ_ALLOC, 16'd64, 8'd8, 10'd0);
		push_item(REQ_ALLOC, 16'd64, 8'd8, 10'd0);
		push_item(REQ_UNUSED, 16'hFFFF, 8'hFF, 10'h3FF);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd0);
		push_item(REQ_ALLOC, 16'd64, 8'd8, 10'd0);
		push_item(REQ_FREE, 16'hFFFF, 8'hFF, 10'h3FF);
		push_item(REQ_ALLOC, 16'd64, 8'd8, 10'h3FF);
		push_item(REQ_RESET, 16'd0, 8'd0, 10'd0);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd5);
		wait_drained();

		// An empty pool, then a single-block pool with a block freed twice.
		write_reg(REG_BLOCK_SIZE, 16'd1);
		write_reg(REG_BLOCK_ALIGN, 16'd0);
		write_reg(REG_BLOCK_COUNT, 16'd0);
		push_item(REQ_RESET, 16'd0, 8'd0, 10'd0);
		push_item(REQ_ALLOC, 16'd1, 8'd0, 10'd0);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd7);
		push_item(REQ_ALLOC, 16'd1, 8'd0, 10'd0);
		push_item(REQ_ALLOC, 16'd1, 8'd0, 10'd0);
		wait_drained();
		write_reg(REG_BLOCK_SIZE, 16'hFFFF);
		write_reg(REG_BLOCK_ALIGN, 16'hFF);
		write_reg(REG_BLOCK_COUNT, 16'd1);
		push_item(REQ_RESET, 16'd0, 8'd0, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd0);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		wait_drained();

		// Count above the pool size, the pool drained completely, then the used
		// total pushed past its maximum by shrinking and regrowing the block size.
		tx_gap_max = 0;
		rx_gap_max = 0;
		write_reg(REG_BLOCK_COUNT, 16'd2047);
		push_item(REQ_RESET, 16'd0, 8'd0, 10'd0);
		repeat (NUM_BLOCKS_DEF + 1)
			push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, BLOCK_W'($urandom()));
		wait_drained();
		write_reg(REG_BLOCK_SIZE, 16'd1);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd10);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd20);
		push_item(REQ_FREE, 16'd0, 8'd0, 10'd30);
		wait_drained();
		write_reg(REG_BLOCK_SIZE, 16'hFFFF);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		push_item(REQ_ALLOC, 16'hFFFF, 8'hFF, 10'd0);
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			write_reg(REG_BLOCK_SIZE, (p == 0) ? 16'd1 : (p == 1) ? 16'hFFFF :
				CFG_DATA_W'($urandom_range(1, 16'hFFFF)));
			write_reg(REG_BLOCK_ALIGN, (p == 0) ? 16'd0 : (p == 1) ? 16'hFF :
				CFG_DATA_W'($urandom_range(0, 8'hFF)));
			write_reg(REG_BLOCK_COUNT, (p == 3) ? 16'd2047 : (p == 1) ? 16'd1 :
				CFG_DATA_W'($urandom_range(2, 24)));
			tx_gap_max = (p % 2) ? 15 : 0;
			rx_gap_max = (p % 3 == 0) ? 0 : 15;
			push_item(REQ_RESET, 16'd0, 8'd0, 10'd0);
			if (p == 2) begin
				tx_gap_max = 0;
				long_asked++;
			end
			for (int k = 0; k < 100; k++) begin
				push_random_item();
				if (k == 49)
					wait_drained();
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
